/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the RTL; expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Implication checked on every rising edge outside reset.
`define ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

/* design/epa_pkg.sv */
// ----------------------------------------------------------------------------
// epa_pkg
// Shared sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none
package epa_pkg;

  localparam int MAX_EDGES  = 1024;
  localparam int NODE_COUNT = 1024;
  localparam int ID_W   = 10;
  localparam int EIDX_W = $clog2(MAX_EDGES);
  localparam int NIDX_W = $clog2(NODE_COUNT);
  localparam int CNT_W  = $clog2(MAX_EDGES + 2);
  localparam int BAL_W  = $clog2(MAX_EDGES + 1) + 2;

  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_READ    = 2'd1;
  localparam logic [1:0] FUNC_RESTART = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NONE    = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  typedef struct packed {
    logic cap_in;
    logic st_edge;
    logic set_drop;
    logic restart;
    logic clr_wr;
    logic bal_rd_src;
    logic bal_wr_src;
    logic bal_rd_dst;
    logic bal_wr_dst;
    logic set_done;
    logic scan_rd;
    logic scan_next;
    logic push_start;
    logic e_chk;
    logic e_next;
    logic push_best;
    logic pop;
    logic pop_load;
    logic out_ld;
  } epa_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic drop_cond;
    logic walk_done;
    logic edge_zero;
    logic bal_is_one;
    logic scan_last;
    logic e_last;
    logic can_push;
    logic pop_empty;
    logic out_full;
  } epa_stat_t;

endpackage
`default_nettype wire

/* design/epa_ctrl.sv */
// ----------------------------------------------------------------------------
// epa_ctrl
// Sequencer: clearing sweep, edge loads, Hierholzer walk and pair reads.
// ----------------------------------------------------------------------------
`default_nettype none
module epa_ctrl (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  input  wire [1:0]            func,
  output logic                 in_ready,
  input  epa_pkg::epa_stat_t   stat,
  output epa_pkg::epa_cmd_t    cmd
);
  import epa_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_LD_RS = 4'd2;
  localparam logic [3:0] S_LD_WS = 4'd3;
  localparam logic [3:0] S_LD_RD = 4'd4;
  localparam logic [3:0] S_LD_WD = 4'd5;
  localparam logic [3:0] S_WINIT = 4'd6;
  localparam logic [3:0] S_SC_RD = 4'd7;
  localparam logic [3:0] S_SC_CK = 4'd8;
  localparam logic [3:0] S_E_RD  = 4'd9;
  localparam logic [3:0] S_E_CK  = 4'd10;
  localparam logic [3:0] S_DEC   = 4'd11;
  localparam logic [3:0] S_POP   = 4'd12;
  localparam logic [3:0] S_R_RD  = 4'd13;
  localparam logic [3:0] S_R_OUT = 4'd14;

  logic [3:0] state, state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE) && !stat.out_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.cap_in = 1'b1;
          case (func)
            FUNC_LOAD: begin
              if (!stat.walk_done) begin
                if (stat.drop_cond) begin
                  cmd.set_drop = 1'b1;
                end else begin
                  cmd.st_edge = 1'b1;
                  state_next  = S_LD_RS;
                end
              end
            end
            FUNC_READ: begin
              if (stat.walk_done) begin
                state_next = S_R_RD;
              end else begin
                cmd.set_done = 1'b1;
                state_next   = S_WINIT;
              end
            end
            FUNC_RESTART: begin
              cmd.restart = 1'b1;
              state_next  = S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      S_LD_RS: begin
        cmd.bal_rd_src = 1'b1;
        state_next     = S_LD_WS;
      end
      S_LD_WS: begin
        cmd.bal_wr_src = 1'b1;
        state_next     = S_LD_RD;
      end
      S_LD_RD: begin
        cmd.bal_rd_dst = 1'b1;
        state_next     = S_LD_WD;
      end
      S_LD_WD: begin
        cmd.bal_wr_dst = 1'b1;
        state_next     = S_IDLE;
      end
      S_WINIT: begin
        state_next = stat.edge_zero ? S_R_RD : S_SC_RD;
      end
      S_SC_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = S_SC_CK;
      end
      S_SC_CK: begin
        if (stat.bal_is_one || stat.scan_last) begin
          cmd.push_start = 1'b1;
          state_next     = S_E_RD;
        end else begin
          cmd.scan_next = 1'b1;
          state_next    = S_SC_RD;
        end
      end
      S_E_RD: begin
        state_next = S_E_CK;
      end
      S_E_CK: begin
        cmd.e_chk = 1'b1;
        if (stat.e_last) begin
          state_next = S_DEC;
        end else begin
          cmd.e_next = 1'b1;
          state_next = S_E_RD;
        end
      end
      S_DEC: begin
        if (stat.can_push) begin
          cmd.push_best = 1'b1;
          state_next    = S_E_RD;
        end else begin
          cmd.pop    = 1'b1;
          state_next = stat.pop_empty ? S_R_RD : S_POP;
        end
      end
      S_POP: begin
        cmd.pop_load = 1'b1;
        state_next   = S_E_RD;
      end
      S_R_RD: begin
        state_next = S_R_OUT;
      end
      S_R_OUT: begin
        cmd.out_ld = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else     state <= state_next;
  end

endmodule
`default_nettype wire

/* design/epa_dp.sv */
// ----------------------------------------------------------------------------
// epa_dp
// Datapath: edge, balance, stack and path memories, counters, output word.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module epa_dp (
  input  wire                      clk,
  input  wire                      rst,
  input  wire [epa_pkg::ID_W-1:0]  in_from,
  input  wire [epa_pkg::ID_W-1:0]  in_to,
  input  epa_pkg::epa_cmd_t        cmd,
  output epa_pkg::epa_stat_t       stat,
  output logic                     out_valid,
  input  wire                      out_ready,
  output logic [epa_pkg::ID_W-1:0] out_from,
  output logic [epa_pkg::ID_W-1:0] out_to,
  output logic                     out_last,
  output logic [1:0]               out_status
);
  import epa_pkg::*;

  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_EDGES);
  localparam logic [ID_W:0]    NODE_LIM = (ID_W+1)'(NODE_COUNT);

  // memories
  logic [ID_W-1:0]  src_mem  [0:MAX_EDGES-1];
  logic [ID_W-1:0]  tgt_mem  [0:MAX_EDGES-1];
  logic             used_mem [0:MAX_EDGES-1];
  logic [BAL_W-1:0] bal_mem  [0:NODE_COUNT-1];
  logic [ID_W-1:0]  stk_mem  [0:MAX_EDGES];
  logic [ID_W-1:0]  path_mem [0:MAX_EDGES];

  // control registers
  logic [CNT_W-1:0]  edge_total, stack_depth, path_len, read_idx;
  logic              walk_done, dropped;
  logic [NIDX_W-1:0] clr_idx, scan_n;
  logic [EIDX_W-1:0] e_idx, best_idx;
  logic              found;

  // payload registers
  logic [ID_W-1:0]  src_q, dst_q, first_src, top, best_tgt;
  logic [ID_W-1:0]  src_rd, tgt_rd, stk_rd, path_a_rd, path_b_rd;
  logic             used_rd;
  logic [BAL_W-1:0] bal_rd;

  logic             bal_we;
  logic [NIDX_W-1:0] bal_waddr, bal_raddr;
  logic [BAL_W-1:0] bal_wdata;
  logic             better;
  logic [CNT_W-1:0] path_ra, path_rb, stk_ra;
  logic             rd_ok;

  always_comb begin
    bal_we    = cmd.clr_wr || cmd.bal_wr_src || cmd.bal_wr_dst;
    bal_waddr = cmd.clr_wr ? clr_idx : (cmd.bal_wr_dst ? dst_q : src_q);
    bal_wdata = cmd.clr_wr ? '0 : (cmd.bal_wr_dst ? bal_rd - 1'b1 : bal_rd + 1'b1);
    bal_raddr = cmd.scan_rd ? scan_n : (cmd.bal_rd_dst ? dst_q : src_q);
  end

  always_ff @(posedge clk) begin
    if (bal_we) bal_mem[bal_waddr] <= bal_wdata;
    bal_rd <= bal_mem[bal_raddr];
  end

  always_ff @(posedge clk) begin
    if (cmd.st_edge) begin
      src_mem[edge_total[EIDX_W-1:0]] <= in_from;
      tgt_mem[edge_total[EIDX_W-1:0]] <= in_to;
    end
    src_rd <= src_mem[e_idx];
    tgt_rd <= tgt_mem[e_idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.st_edge)        used_mem[edge_total[EIDX_W-1:0]] <= 1'b0;
    else if (cmd.push_best) used_mem[best_idx] <= 1'b1;
    used_rd <= used_mem[e_idx];
  end

  assign stk_ra = stack_depth - CNT_W'(2);

  always_ff @(posedge clk) begin
    if (cmd.push_start)     stk_mem[0] <= (stat.bal_is_one ? scan_n : first_src);
    else if (cmd.push_best) stk_mem[stack_depth] <= best_tgt;
    stk_rd <= stk_mem[stk_ra];
  end

  assign path_ra = path_len - CNT_W'(1) - read_idx;
  assign path_rb = path_ra - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.pop && path_len <= MAX_CNT) path_mem[path_len] <= top;
    path_a_rd <= path_mem[path_ra];
    path_b_rd <= path_mem[path_rb];
  end

  // smallest target wins; strict compare keeps the lowest load position on ties
  assign better = !used_rd && (src_rd == top) && (!found || (tgt_rd < best_tgt));
  assign rd_ok  = (path_len >= CNT_W'(2)) && (read_idx < path_len - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      src_q <= in_from;
      dst_q <= in_to;
    end
    if (cmd.st_edge && edge_total == '0) first_src <= in_from;
    if (cmd.restart) first_src <= '0;
    if (cmd.push_start) top <= stat.bal_is_one ? scan_n : first_src;
    if (cmd.push_best)  top <= best_tgt;
    if (cmd.pop_load)   top <= stk_rd;
    if (cmd.e_chk && better) begin
      best_idx <= e_idx;
      best_tgt <= tgt_rd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.restart) begin
      edge_total  <= '0;
      stack_depth <= '0;
      path_len    <= '0;
      read_idx    <= '0;
      walk_done   <= 1'b0;
      dropped     <= 1'b0;
      clr_idx     <= '0;
      scan_n      <= '0;
      e_idx       <= '0;
      found       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clr_wr)   clr_idx <= clr_idx + 1'b1;
      if (cmd.set_drop) dropped <= 1'b1;
      if (cmd.st_edge)  edge_total <= edge_total + 1'b1;
      if (cmd.set_done) walk_done <= 1'b1;
      if (cmd.scan_next) scan_n <= scan_n + 1'b1;
      if (cmd.push_start) begin
        stack_depth <= CNT_W'(1);
        path_len    <= '0;
        e_idx       <= '0;
        found       <= 1'b0;
      end
      if (cmd.e_chk && better) found <= 1'b1;
      if (cmd.e_next) e_idx <= e_idx + 1'b1;
      if (cmd.push_best || cmd.pop_load) begin
        e_idx <= '0;
        found <= 1'b0;
      end
      if (cmd.push_best) stack_depth <= stack_depth + 1'b1;
      if (cmd.pop) begin
        stack_depth <= stack_depth - 1'b1;
        if (path_len <= MAX_CNT) path_len <= path_len + 1'b1;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.out_ld) begin
        out_valid <= 1'b1;
        if (rd_ok) read_idx <= read_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_ld) begin
      if (rd_ok) begin
        out_from   <= path_a_rd;
        out_to     <= path_b_rd;
        out_last   <= (read_idx == path_len - CNT_W'(2));
        out_status <= dropped ? ST_DROPPED : ST_OK;
      end else begin
        out_from   <= '0;
        out_to     <= '0;
        out_last   <= 1'b0;
        out_status <= ST_NONE;
      end
    end
  end

  always_comb begin
    stat.clr_last   = (clr_idx == NIDX_W'(NODE_COUNT - 1));
    stat.drop_cond  = ({1'b0, in_from} >= NODE_LIM) || ({1'b0, in_to} >= NODE_LIM) ||
                      (edge_total == MAX_CNT);
    stat.walk_done  = walk_done;
    stat.edge_zero  = (edge_total == '0);
    stat.bal_is_one = (bal_rd == BAL_W'(1));
    stat.scan_last  = (scan_n == NIDX_W'(NODE_COUNT - 1));
    stat.e_last     = ({1'b0, e_idx} == edge_total - CNT_W'(1));
    stat.can_push   = found && (stack_depth <= MAX_CNT);
    stat.pop_empty  = (stack_depth == CNT_W'(1));
    stat.out_full   = out_valid;
  end

  `ASSERT_IMP(a_out_ld_empty, cmd.out_ld, !out_valid, "output word overwritten")
  `ASSERT_CLK(a_stack_bound, stack_depth <= MAX_CNT + CNT_W'(1), "stack depth overflow")
  `ASSERT_CLK(a_path_bound, path_len <= MAX_CNT + CNT_W'(1), "path length overflow")
  `ASSERT_IMP(a_push_found, cmd.push_best, found, "push without a chosen edge")

endmodule
`default_nettype wire

/* design/eulerian_path_arranger.sv */
// ----------------------------------------------------------------------------
// eulerian_path_arranger
// Loads directed edges, runs Hierholzer's walk once, streams the path pairs.
// ----------------------------------------------------------------------------
// Input words (s_*): s_tuser carries the function (load, read, restart),
// s_tdata the edge. An accepted load does a read-modify-write of the source
// and target balance, unless it is dropped or comes after the walk. Once the
// walk has run, a read gives one output word. The next input word is taken in
// the cycle after that word leaves. The first read runs the walk: a scan of
// the balance memory for the first node of balance one and then, per walk
// step, a pass over all loaded edges. Loads, restarts and the unused function
// give no output word.
// After reset and after each restart the balance memory is swept to zero;
// s_tready stays low during the sweep.
// Output words (m_*) sit in an output register; while the receiver stalls the
// block holds the word and takes no new input word.
// ----------------------------------------------------------------------------
`default_nettype none
module eulerian_path_arranger (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // [9:0] edge_from, [19:10] edge_to, [23:20] zero
  input  wire  [1:0]  s_tuser,   // [1:0] func
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [23:0] m_tdata,   // [9:0] pair_from, [19:10] pair_to, [23:20] zero
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last_pair
);
  import epa_pkg::*;

  epa_cmd_t        cmd;
  epa_stat_t       stat;
  logic [ID_W-1:0] pair_from, pair_to;

  epa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  epa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .in_from    (s_tdata[9:0]),
    .in_to      (s_tdata[19:10]),
    .cmd        (cmd),
    .stat       (stat),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_from   (pair_from),
    .out_to     (pair_to),
    .out_last   (m_tlast),
    .out_status (m_tuser)
  );

  assign m_tdata = {4'b0, pair_to, pair_from};

endmodule
`default_nettype wire

/* verif/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Streams edge loads, reads and restarts into eulerian_path_arranger and
// checks every output word against a cycle-free predictor of the walk.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module testbench;
  import epa_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [9:0] pfrom;
    logic [9:0] pto;
    logic       last;
    logic [1:0] status;
  } pair_t;

  class pair_scoreboard;
    logic [9:0] esrc [MAX_EDGES];
    logic [9:0] edst [MAX_EDGES];
    bit         used [MAX_EDGES];
    int         bal  [NODE_COUNT];
    logic [9:0] stk  [MAX_EDGES + 1];
    logic [9:0] path [MAX_EDGES + 1];
    int         total, depth, plen, ridx;
    bit         done, dropped;
    logic [9:0] first;
    pair_t      pending[$];
    int         errors, checked;

    function void clear();
      for (int i = 0; i < MAX_EDGES; i++) used[i] = 0;
      for (int i = 0; i < NODE_COUNT; i++) bal[i] = 0;
      total = 0; depth = 0; plen = 0; ridx = 0;
      done = 0; dropped = 0; first = '0;
    endfunction

    function void walk();
      logic [9:0] top;
      int best;
      bit found;
      done = 1;
      if (total == 0) return;
      top = first;
      for (int n = 0; n < NODE_COUNT; n++)
        if (bal[n] == 1) begin
          top = n[9:0];
          break;
        end
      depth = 0; plen = 0;
      stk[depth++] = top;
      while (depth > 0) begin
        top = stk[depth - 1];
        found = 0; best = 0;
        for (int e = 0; e < total; e++)
          if (!used[e] && esrc[e] == top && (!found || edst[e] < edst[best])) begin
            best = e; found = 1;
          end
        if (found && depth <= MAX_EDGES) begin
          used[best] = 1;
          stk[depth++] = edst[best];
        end else begin
          depth--;
          if (plen <= MAX_EDGES) path[plen++] = top;
        end
      end
    endfunction

    function void note(logic [1:0] fn, logic [9:0] a, logic [9:0] b);
      pair_t p;
      int k;
      if (fn == FUNC_RESTART) clear();
      else if (fn == FUNC_LOAD) begin
        if (done) return;
        if (total >= MAX_EDGES) begin
          dropped = 1;
          return;
        end
        if (total == 0) first = a;
        esrc[total] = a; edst[total] = b; used[total] = 0;
        bal[a] += 1; bal[b] -= 1;
        total++;
      end else if (fn == FUNC_READ) begin
        if (!done) walk();
        if (plen >= 2 && ridx < plen - 1) begin
          k = plen - 1 - ridx;
          p.pfrom = path[k]; p.pto = path[k - 1];
          p.last = (ridx == plen - 2);
          p.status = dropped ? ST_DROPPED : ST_OK;
          ridx++;
        end else begin
          p = '0;
          p.status = ST_NONE;
        end
        pending = {pending, p};
      end
    endfunction

    function void check(pair_t got);
      pair_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word from=%0d to=%0d last=%0d status=%0d",
                 $time, got.pfrom, got.pto, got.last, got.status);
        errors++;
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.pfrom !== want.pfrom)
        $display("%0t: pair_from expected %0d actual %0d", $time, want.pfrom, got.pfrom);
      if (got.pto !== want.pto)
        $display("%0t: pair_to expected %0d actual %0d", $time, want.pto, got.pto);
      if (got.last !== want.last)
        $display("%0t: last_pair expected %0d actual %0d", $time, want.last, got.last);
      if (got.status !== want.status)
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
      if (got !== want) errors++;
    endfunction
  endclass

  logic        clk = 0, rst = 1;
  logic        s_tvalid = 0, m_tready = 0;
  logic [23:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  wire         s_tready, m_tvalid, m_tlast;
  wire  [23:0] m_tdata;
  wire  [1:0]  m_tuser;

  eulerian_path_arranger uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  pair_scoreboard sb = new();
  int words_sent, burst_left, phases;
  bit hold;

  function automatic logic [9:0] rand_id();
    return 10'($urandom);
  endfunction

  // Drive one word, holding it until the block takes it.
  task automatic send(logic [1:0] fn, logic [9:0] a, logic [9:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1;
    s_tuser  <= fn;
    s_tdata  <= {4'd0, b, a};
    forever begin
      @(negedge clk);
      if (s_tready) break;
    end
    @(posedge clk);
    sb.note(fn, a, b);
    words_sent++;
  endtask

  task automatic read_all(int n);
    for (int i = 0; i < n; i++) send(FUNC_READ, rand_id(), rand_id());
  endtask

  // Random graph phase: mostly an Eulerian trail over a few nodes.
  task automatic graph_phase();
    logic [9:0] pool [8];
    logic [9:0] va [32], vb [32], tmp, cur;
    int ne, np, j;
    ne = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 28) : $urandom_range(1, 12);
    np = $urandom_range(1, 8);
    for (int i = 0; i < np; i++) pool[i] = rand_id();
    if ($urandom_range(0, 3) == 0) pool[0] = 10'd1023;
    if ($urandom_range(0, 3) == 0) pool[np - 1] = 10'd0;
    cur = pool[$urandom_range(0, np - 1)];
    for (int i = 0; i < ne; i++) begin
      va[i] = cur;
      cur = pool[$urandom_range(0, np - 1)];
      vb[i] = cur;
      if ($urandom_range(0, 7) == 0) begin
        va[i] = pool[$urandom_range(0, np - 1)];
        vb[i] = pool[$urandom_range(0, np - 1)];
      end
    end
    for (int i = ne - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = va[i]; va[i] = va[j]; va[j] = tmp;
      tmp = vb[i]; vb[i] = vb[j]; vb[j] = tmp;
    end
    for (int i = 0; i < ne; i++) begin
      if ($urandom_range(0, 12) == 0) send(FUNC_UNUSED, rand_id(), rand_id());
      send(FUNC_LOAD, va[i], vb[i]);
    end
    read_all(ne + $urandom_range(0, 2));
    if ($urandom_range(0, 4) == 0) begin
      send(FUNC_LOAD, rand_id(), rand_id());
      read_all(1);
    end
    send(FUNC_RESTART, rand_id(), rand_id());
    phases++;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 0;
    send(FUNC_READ, 10'd0, 10'd0);          // no edges at all
    send(FUNC_LOAD, 10'd0, 10'd1023);
    send(FUNC_LOAD, 10'd1023, 10'd0);
    send(FUNC_LOAD, 10'd0, 10'd0);          // self loop
    send(FUNC_LOAD, 10'd1023, 10'd1023);
    send(FUNC_UNUSED, 10'd1023, 10'd1023);
    read_all(6);                            // past the final pair
    send(FUNC_LOAD, 10'd5, 10'd6);          // ignored after the walk
    read_all(1);
    send(FUNC_RESTART, 10'd1023, 10'd1023);
    send(FUNC_LOAD, 10'd3, 10'd7);
    send(FUNC_LOAD, 10'd7, 10'd3);
    read_all(3);
    send(FUNC_RESTART, 10'd0, 10'd0);
    words_sent = 0;
    while (words_sent < 600) graph_phase();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Ran %0d graph phases plus directed cases and one long receiver hold-off,",
             phases);
    $display("%0d output words checked.", sb.checked);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off to back up the input.
  initial begin
    repeat (3000) @(posedge clk);
    do @(negedge clk); while (!m_tvalid);
    hold = 1;
    repeat (400) @(negedge clk);
    hold = 0;
  end

  always @(posedge clk)
    if (hold) m_tready <= 1'b0;
    else      m_tready <= ($time / 97) % 5 == 0 ? ($urandom_range(0, 3) == 0) : 1'b1;

  always @(negedge clk)
    if (!rst && m_tvalid && m_tready)
      sb.check({m_tdata[9:0], m_tdata[19:10], m_tlast, m_tuser});

  initial begin
    #2ms;
    $display("CHECK FAILED");
    $finish;
  end
endmodule
`default_nettype wire

/* eulerian_path_arranger.f */
+incdir+design
design/epa_pkg.sv
design/epa_ctrl.sv
design/epa_dp.sv
design/eulerian_path_arranger.sv
verif/testbench.sv
